>>> design/cmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmt_pkg: shared types, constants and microcode for the core mask trimmer
// Holds the payload structs, status and register codes, and the control
// store that sequences one trim request through the datapath.
// ----------------------------------------------------------------------------
package cmt_pkg;

    localparam int MASK_W      = 64;
    localparam int MIDX_W      = 6;
    localparam int POS_W       = 7;
    localparam int NB_W        = 11;
    localparam int CPU_W       = 16;
    localparam int THR_W       = 8;
    localparam int STAT_W      = 2;
    localparam int CORE_BITS   = 64;
    localparam int MAX_SOCKETS_DEF = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int UPC_W       = 4;
    localparam int OP_W        = 4;
    localparam int COND_W      = 4;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_SHORT = 2'd1;
    localparam logic [STAT_W-1:0] ST_WIDE  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THREADS = 1'd1;

    // Microcode step addresses.
    localparam logic [UPC_W-1:0] U_IDLE = 4'd0;
    localparam logic [UPC_W-1:0] U_NB   = 4'd1;
    localparam logic [UPC_W-1:0] U_CHK  = 4'd2;
    localparam logic [UPC_W-1:0] U_ZERO = 4'd3;
    localparam logic [UPC_W-1:0] U_MODE = 4'd4;
    localparam logic [UPC_W-1:0] U_BLK  = 4'd5;
    localparam logic [UPC_W-1:0] U_INIT = 4'd6;
    localparam logic [UPC_W-1:0] U_NEWR = 4'd7;
    localparam logic [UPC_W-1:0] U_CYC  = 4'd8;
    localparam logic [UPC_W-1:0] U_RND  = 4'd9;
    localparam logic [UPC_W-1:0] U_FIN  = 4'd10;
    localparam logic [UPC_W-1:0] U_WIDE = 4'd11;

    // Datapath operations.
    localparam logic [OP_W-1:0] OP_NONE = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD = 4'd1;
    localparam logic [OP_W-1:0] OP_NB   = 4'd2;
    localparam logic [OP_W-1:0] OP_CHK  = 4'd3;
    localparam logic [OP_W-1:0] OP_CLR  = 4'd4;
    localparam logic [OP_W-1:0] OP_BLK  = 4'd5;
    localparam logic [OP_W-1:0] OP_INIT = 4'd6;
    localparam logic [OP_W-1:0] OP_NEWR = 4'd7;
    localparam logic [OP_W-1:0] OP_CYC  = 4'd8;
    localparam logic [OP_W-1:0] OP_FIN  = 4'd9;
    localparam logic [OP_W-1:0] OP_WIDE = 4'd10;

    // Branch conditions.
    localparam logic [COND_W-1:0] C_NEVER    = 4'd0;
    localparam logic [COND_W-1:0] C_ALWAYS   = 4'd1;
    localparam logic [COND_W-1:0] C_START    = 4'd2;
    localparam logic [COND_W-1:0] C_WIDE     = 4'd3;
    localparam logic [COND_W-1:0] C_ZERO     = 4'd4;
    localparam logic [COND_W-1:0] C_CYCLIC   = 4'd5;
    localparam logic [COND_W-1:0] C_BLK_END  = 4'd6;
    localparam logic [COND_W-1:0] C_S_END    = 4'd7;
    localparam logic [COND_W-1:0] C_MORE     = 4'd8;
    localparam logic [COND_W-1:0] C_OUT_FREE = 4'd9;

    typedef struct packed {
        logic [MASK_W-1:0] core_mask;
        logic [3:0]        socket_count;
        logic [6:0]        cores_per_socket;
        logic [THR_W-1:0]  node_threads;
        logic [CPU_W-1:0]  cpu_count;
    } cmt_in_t;

    typedef struct packed {
        logic [MASK_W-1:0] kept_mask;
        logic [STAT_W-1:0] status;
    } cmt_out_t;

    // One control word: the operation, a branch condition with its target,
    // and whether a false condition holds the step or falls through.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [UPC_W-1:0]  target;
        logic              stay;
    } ctl_word_t;

    function automatic ctl_word_t ucode(input logic [UPC_W-1:0] step);
        ctl_word_t w;
        begin
            case (step)
                U_IDLE:  w = '{op: OP_LOAD, cond: C_START,    target: U_NB,   stay: 1'b1};
                U_NB:    w = '{op: OP_NB,   cond: C_NEVER,    target: U_IDLE, stay: 1'b0};
                U_CHK:   w = '{op: OP_CHK,  cond: C_WIDE,     target: U_WIDE, stay: 1'b0};
                U_ZERO:  w = '{op: OP_NONE, cond: C_ZERO,     target: U_FIN,  stay: 1'b0};
                U_MODE:  w = '{op: OP_CLR,  cond: C_CYCLIC,   target: U_INIT, stay: 1'b0};
                U_BLK:   w = '{op: OP_BLK,  cond: C_BLK_END,  target: U_FIN,  stay: 1'b1};
                U_INIT:  w = '{op: OP_INIT, cond: C_S_END,    target: U_NEWR, stay: 1'b1};
                U_NEWR:  w = '{op: OP_NEWR, cond: C_NEVER,    target: U_IDLE, stay: 1'b0};
                U_CYC:   w = '{op: OP_CYC,  cond: C_S_END,    target: U_RND,  stay: 1'b1};
                U_RND:   w = '{op: OP_NONE, cond: C_MORE,     target: U_NEWR, stay: 1'b0};
                U_FIN:   w = '{op: OP_FIN,  cond: C_OUT_FREE, target: U_IDLE, stay: 1'b1};
                U_WIDE:  w = '{op: OP_WIDE, cond: C_OUT_FREE, target: U_IDLE, stay: 1'b1};
                default: w = '{op: OP_NONE, cond: C_ALWAYS,   target: U_IDLE, stay: 1'b0};
            endcase
            return w;
        end
    endfunction

    // Subtraction that stops at zero.
    function automatic logic [CPU_W-1:0] sat_sub(input logic [CPU_W-1:0] a,
                                                 input logic [THR_W-1:0] b);
        logic [CPU_W-1:0] bx;
        begin
            bx = CPU_W'(b);
            return (a < bx) ? '0 : a - bx;
        end
    endfunction

endpackage
`default_nettype wire

>>> design/core_mask_trim.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// core_mask_trim: trims a node's available-core mask to the cores a job needs
// A microcoded sequencer walks the mask one core bit per cycle, in block
// order or round by round across sockets, and returns the kept mask.
// ----------------------------------------------------------------------------
// Usage:
//   A request enters on in_valid/in_ready and carries the core mask, socket
//   and core counts, threads per core and CPUs wanted. One result per request
//   leaves on out_valid/out_ready. The cfg channel writes the trim mode and
//   thread limit; it is always ready. The user must see that it is written
//   only while idle; the block itself does not enforce this. in_ready is high
//   only while the sequencer sits in its idle step, so one request is worked
//   at a time, but a finished result waits in the output register while the
//   next request is taken and processed. The time a request takes grows with
//   the bit-serial walk of the layout (nb = sockets times cores per socket)
//   and, in cyclic mode, with the number of rounds; an oversized layout or
//   zero CPUs wanted skips the walk. The next request is taken in the cycle
//   after the result is written at the earliest. If the receiver stalls, the
//   sequencer holds in its final step until the output register frees up.
//   Reset returns the sequencer to idle, empties the output register and
//   sets mode 0 and thread limit 1.
// ----------------------------------------------------------------------------
module core_mask_trim #(
    parameter int MAX_SOCKETS = cmt_pkg::MAX_SOCKETS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire cmt_pkg::cmt_in_t                  in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output cmt_pkg::cmt_out_t                      out_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [cmt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cmt_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SC_W = $clog2(MAX_SOCKETS + 1);
    localparam int SI_W = (MAX_SOCKETS > 1) ? $clog2(MAX_SOCKETS) : 1;

    // Configuration registers.
    logic                        mode_reg;
    logic [cmt_pkg::THR_W-1:0]   thr_reg;

    // Sequencer.
    logic [cmt_pkg::UPC_W-1:0]   upc_reg, upc_next;
    cmt_pkg::ctl_word_t          ctl;
    logic                        cond_hit;

    // Datapath.
    logic [cmt_pkg::MASK_W-1:0]  avail_reg, avail_next;
    logic [3:0]                  socks_reg, socks_next;
    logic [6:0]                  cps_reg, cps_next;
    logic [cmt_pkg::THR_W-1:0]   nthr_reg, nthr_next;
    logic [cmt_pkg::CPU_W-1:0]   cpus_reg, cpus_next;
    logic [cmt_pkg::NB_W-1:0]    nb_reg, nb_next;
    logic [cmt_pkg::THR_W-1:0]   tpc_reg, tpc_next;
    logic [cmt_pkg::MASK_W-1:0]  kept_reg, kept_next;
    logic [cmt_pkg::POS_W-1:0]   k_reg, k_next;
    logic [SC_W-1:0]             s_reg, s_next;
    logic [cmt_pkg::POS_W-1:0]   base_reg, base_next;
    logic                        any_reg, any_next;
    logic [cmt_pkg::CPU_W-1:0]   before_reg, before_next;

    logic [cmt_pkg::POS_W-1:0]   pos_reg [MAX_SOCKETS];
    logic [cmt_pkg::POS_W-1:0]   end_reg [MAX_SOCKETS];
    logic                        pos_wr;
    logic [cmt_pkg::POS_W-1:0]   pos_wdata;
    logic                        end_wr;
    logic [cmt_pkg::POS_W-1:0]   end_wdata;

    logic                        out_valid_reg, out_valid_next;
    cmt_pkg::cmt_out_t           out_data_reg, out_data_next;

    logic [cmt_pkg::MASK_W-1:0]  layout_mask;
    logic [SC_W-1:0]             socks_s;
    logic [SI_W-1:0]             sidx;
    logic [cmt_pkg::POS_W-1:0]   pos_rd;
    logic [cmt_pkg::POS_W-1:0]   end_rd;
    logic [cmt_pkg::POS_W-1:0]   nb_pos;
    logic                        s_end;
    logic                        blk_end;
    logic                        out_free;

    assign ctl       = cmt_pkg::ucode(upc_reg);
    assign in_ready  = (upc_reg == cmt_pkg::U_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign socks_s  = SC_W'(socks_reg);
    assign sidx     = s_reg[SI_W-1:0];
    assign pos_rd   = pos_reg[sidx];
    assign end_rd   = end_reg[sidx];
    assign nb_pos   = nb_reg[cmt_pkg::POS_W-1:0];
    assign s_end    = (s_reg == socks_s);
    assign blk_end  = (k_reg == nb_pos) || (cpus_reg == '0);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        for (int i = 0; i < cmt_pkg::MASK_W; i++)
        begin
            layout_mask[i] = (cmt_pkg::NB_W'(i) < nb_reg);
        end
    end

    always_comb
    begin
        case (ctl.cond)
            cmt_pkg::C_NEVER:    cond_hit = 1'b0;
            cmt_pkg::C_ALWAYS:   cond_hit = 1'b1;
            cmt_pkg::C_START:    cond_hit = in_valid;
            cmt_pkg::C_WIDE:     cond_hit = (nb_reg > cmt_pkg::NB_W'(cmt_pkg::CORE_BITS))
                                         || (5'(socks_reg) > 5'(MAX_SOCKETS));
            cmt_pkg::C_ZERO:     cond_hit = (cpus_reg == '0);
            cmt_pkg::C_CYCLIC:   cond_hit = mode_reg;
            cmt_pkg::C_BLK_END:  cond_hit = blk_end;
            cmt_pkg::C_S_END:    cond_hit = s_end;
            cmt_pkg::C_MORE:     cond_hit = any_reg && (before_reg != cpus_reg)
                                         && (cpus_reg != '0);
            cmt_pkg::C_OUT_FREE: cond_hit = out_free;
            default:             cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        if (cond_hit)
        begin
            upc_next = ctl.target;
        end
        else if (ctl.stay)
        begin
            upc_next = upc_reg;
        end
        else
        begin
            upc_next = upc_reg + 1'b1;
        end
    end

    always_comb
    begin
        avail_next     = avail_reg;
        socks_next     = socks_reg;
        cps_next       = cps_reg;
        nthr_next      = nthr_reg;
        cpus_next      = cpus_reg;
        nb_next        = nb_reg;
        tpc_next       = tpc_reg;
        kept_next      = kept_reg;
        k_next         = k_reg;
        s_next         = s_reg;
        base_next      = base_reg;
        any_next       = any_reg;
        before_next    = before_reg;
        pos_wr         = 1'b0;
        pos_wdata      = pos_rd;
        end_wr         = 1'b0;
        end_wdata      = end_rd;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        case (ctl.op)
            cmt_pkg::OP_NONE:
            begin
            end
            cmt_pkg::OP_LOAD:
            begin
                if (in_valid)
                begin
                    avail_next = in_data.core_mask;
                    socks_next = in_data.socket_count;
                    cps_next   = in_data.cores_per_socket;
                    nthr_next  = in_data.node_threads;
                    cpus_next  = in_data.cpu_count;
                end
            end
            cmt_pkg::OP_NB:
            begin
                nb_next  = cmt_pkg::NB_W'(socks_reg) * cmt_pkg::NB_W'(cps_reg);
                tpc_next = (thr_reg < nthr_reg) ? thr_reg : nthr_reg;
            end
            cmt_pkg::OP_CHK:
            begin
                avail_next = avail_reg & layout_mask;
                kept_next  = '0;
            end
            cmt_pkg::OP_CLR:
            begin
                k_next    = '0;
                s_next    = '0;
                base_next = '0;
            end
            cmt_pkg::OP_BLK:
            begin
                if (!blk_end)
                begin
                    if (avail_reg[k_reg[cmt_pkg::MIDX_W-1:0]])
                    begin
                        kept_next = kept_reg
                                  | (cmt_pkg::MASK_W'(1) << k_reg[cmt_pkg::MIDX_W-1:0]);
                        cpus_next = cmt_pkg::sat_sub(cpus_reg, tpc_reg);
                    end
                    k_next = k_reg + 1'b1;
                end
            end
            cmt_pkg::OP_INIT:
            begin
                // Lay out each socket's scan window: start at its first core.
                if (!s_end)
                begin
                    pos_wr    = 1'b1;
                    pos_wdata = base_reg;
                    end_wr    = 1'b1;
                    end_wdata = base_reg + cps_reg;
                    base_next = base_reg + cps_reg;
                    s_next    = s_reg + 1'b1;
                end
            end
            cmt_pkg::OP_NEWR:
            begin
                s_next      = '0;
                any_next    = 1'b0;
                before_next = cpus_reg;
            end
            cmt_pkg::OP_CYC:
            begin
                // One bit per cycle: skip a clear core, or keep a set one and
                // move to the next socket; an exhausted socket is passed over.
                if (!s_end)
                begin
                    if (pos_rd == end_rd)
                    begin
                        s_next = s_reg + 1'b1;
                    end
                    else if (avail_reg[pos_rd[cmt_pkg::MIDX_W-1:0]])
                    begin
                        kept_next = kept_reg
                                  | (cmt_pkg::MASK_W'(1) << pos_rd[cmt_pkg::MIDX_W-1:0]);
                        cpus_next = cmt_pkg::sat_sub(cpus_reg, tpc_reg);
                        pos_wr    = 1'b1;
                        pos_wdata = pos_rd + 1'b1;
                        any_next  = 1'b1;
                        s_next    = s_reg + 1'b1;
                    end
                    else
                    begin
                        pos_wr    = 1'b1;
                        pos_wdata = pos_rd + 1'b1;
                    end
                end
            end
            cmt_pkg::OP_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (cpus_reg != '0)
                    begin
                        out_data_next.kept_mask = avail_reg;
                        out_data_next.status    = cmt_pkg::ST_SHORT;
                    end
                    else
                    begin
                        out_data_next.kept_mask = kept_reg;
                        out_data_next.status    = cmt_pkg::ST_OK;
                    end
                end
            end
            cmt_pkg::OP_WIDE:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.kept_mask = '0;
                    out_data_next.status    = cmt_pkg::ST_WIDE;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= cmt_pkg::U_IDLE;
            out_valid_reg <= 1'b0;
            mode_reg      <= 1'b0;
            thr_reg       <= cmt_pkg::THR_W'(1);
        end
        else
        begin
            upc_reg       <= upc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cmt_pkg::REG_MODE:    mode_reg <= cfg_data[0];
                    cmt_pkg::REG_THREADS: thr_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        avail_reg    <= avail_next;
        socks_reg    <= socks_next;
        cps_reg      <= cps_next;
        nthr_reg     <= nthr_next;
        cpus_reg     <= cpus_next;
        nb_reg       <= nb_next;
        tpc_reg      <= tpc_next;
        kept_reg     <= kept_next;
        k_reg        <= k_next;
        s_reg        <= s_next;
        base_reg     <= base_next;
        any_reg      <= any_next;
        before_reg   <= before_next;
        out_data_reg <= out_data_next;
        if (pos_wr)
        begin
            pos_reg[sidx] <= pos_wdata;
        end
        if (end_wr)
        begin
            end_reg[sidx] <= end_wdata;
        end
    end

`ifndef SYNTHESIS
    a_wide_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status == cmt_pkg::ST_WIDE)
            |-> (out_data_reg.kept_mask == '0))
        else $error("wide layout result carries a nonzero mask");

    a_socket_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == cmt_pkg::U_CYC) |-> (s_reg <= socks_s))
        else $error("socket index ran past the socket count");

    a_cpus_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == cmt_pkg::U_BLK || upc_reg == cmt_pkg::U_CYC)
            |=> (cpus_reg <= $past(cpus_reg)))
        else $error("remaining CPU count grew during a walk");

    a_kept_subset: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == cmt_pkg::U_FIN) |-> ((kept_reg & ~avail_reg) == '0))
        else $error("kept mask holds a core that is not available");

    a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == cmt_pkg::U_CYC && s_reg < socks_s) |-> (pos_rd <= end_rd))
        else $error("socket scan position passed the end of its socket");
`endif

endmodule
`default_nettype wire

>>> tb/tb_core_mask_trim.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_core_mask_trim: self-checking testbench for the core mask trimmer
// Sends directed and random trim requests in block and cyclic mode under
// several thread limits and idle patterns. An in-bench predictor computes the
// expected kept mask and status of every accepted request, and each result is
// compared field by field, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_core_mask_trim;

    localparam logic TRIM_BLOCK  = 1'b0;
    localparam logic TRIM_CYCLIC = 1'b1;
    localparam int   STALL_LIMIT = 5000;
    localparam int   DRAIN_CYCLES = 400;
    localparam int   SEGMENT_REQUESTS = 205;
    localparam int   MAX_PRINTED = 40;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    cmt_pkg::cmt_in_t               in_data;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    cmt_pkg::cmt_out_t              out_data;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [cmt_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cmt_pkg::CFG_DATA_W-1:0] cfg_data;

    // Bench copy of the configuration registers.
    logic                           trim_mode_q;
    logic [cmt_pkg::THR_W-1:0]      thread_limit_q;

    cmt_pkg::cmt_out_t              expected_trims[$];
    int                             error_count = 0;
    int                             quiet_cycles = 0;
    int                             send_gap_pct;
    int                             recv_stall_pct;

    core_mask_trim uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Computes the kept mask and status for one request under the given settings.
    function automatic cmt_pkg::cmt_out_t predict_trim(input cmt_pkg::cmt_in_t req,
                                                       input logic mode,
                                                       input logic [cmt_pkg::THR_W-1:0] tlimit);
        cmt_pkg::cmt_out_t          res;
        logic [cmt_pkg::MASK_W-1:0] avail;
        logic [cmt_pkg::MASK_W-1:0] kept;
        int                         tpc;
        int                         nb;
        int                         socks;
        int                         cps;
        int                         need;
        int                         prev_need;
        int                         k;
        int                         s;
        int                         pos[cmt_pkg::MAX_SOCKETS_DEF];
        int                         stop[cmt_pkg::MAX_SOCKETS_DEF];
        bit                         any_kept;
        bit                         rounds_on;
        socks = int'(req.socket_count);
        cps   = int'(req.cores_per_socket);
        nb    = socks * cps;
        need  = int'(req.cpu_count);
        tpc   = (tlimit < req.node_threads) ? int'(tlimit) : int'(req.node_threads);
        avail = '0;
        kept  = '0;
        if (nb > cmt_pkg::CORE_BITS || socks > cmt_pkg::MAX_SOCKETS_DEF)
        begin
            res.kept_mask = '0;
            res.status    = cmt_pkg::ST_WIDE;
            return res;
        end
        for (k = 0; k < nb; k++)
            avail[k] = req.core_mask[k];
        if (mode == TRIM_BLOCK)
        begin
            for (k = 0; k < nb && need > 0; k++)
            begin
                if (avail[k])
                begin
                    kept[k] = 1'b1;
                    need = (need < tpc) ? 0 : need - tpc;
                end
            end
        end
        else
        begin
            for (s = 0; s < socks; s++)
            begin
                pos[s]  = s * cps;
                stop[s] = pos[s] + cps;
            end
            rounds_on = (need > 0);
            while (rounds_on)
            begin
                prev_need = need;
                any_kept  = 1'b0;
                // A started round visits every socket even once the count hits zero.
                for (s = 0; s < socks; s++)
                begin
                    while (pos[s] < stop[s] && !avail[pos[s]])
                        pos[s]++;
                    if (pos[s] < stop[s])
                    begin
                        any_kept = 1'b1;
                        need = (need < tpc) ? 0 : need - tpc;
                        pos[s]++;
                    end
                end
                rounds_on = any_kept && (prev_need != need) && (need > 0);
            end
            for (s = 0; s < socks; s++)
                for (k = s * cps; k < pos[s]; k++)
                    kept[k] = avail[k];
        end
        if (need > 0)
        begin
            res.kept_mask = avail;
            res.status    = cmt_pkg::ST_SHORT;
        end
        else
        begin
            res.kept_mask = kept;
            res.status    = cmt_pkg::ST_OK;
        end
        return res;
    endfunction

    // Mostly well-formed layouts sized around the cores that can cover the CPUs.
    function automatic cmt_pkg::cmt_in_t random_request();
        cmt_pkg::cmt_in_t req;
        logic [63:0]      a;
        logic [63:0]      b;
        int               pick;
        int               socks;
        int               cps;
        int               span;
        int               ones;
        int               room;
        int               tpc;
        int               k;
        a     = {$urandom, $urandom};
        b     = {$urandom, $urandom};
        pick  = $urandom_range(99);
        socks = $urandom_range(cmt_pkg::MAX_SOCKETS_DEF, 1);
        if (pick < 6)
        begin
            socks = $urandom_range(cmt_pkg::MAX_SOCKETS_DEF, 2);
            cps   = $urandom_range(64, 64 / socks + 1);
        end
        else
        begin
            span = 64 / socks;
            if ($urandom_range(3) != 0 && span > 8)
                span = 8;
            cps = $urandom_range(span, 1);
        end
        case ($urandom_range(3))
            0:       req.core_mask = '1;
            1:       req.core_mask = a & b;
            2:       req.core_mask = a;
            default: req.core_mask = a | b;
        endcase
        req.socket_count     = 4'(socks);
        req.cores_per_socket = 7'(cps);
        if ($urandom_range(3) == 0)
            req.node_threads = 8'($urandom_range(255, 1));
        else
            req.node_threads = 8'($urandom_range(4, 1));
        tpc = (thread_limit_q < req.node_threads) ? int'(thread_limit_q)
                                                  : int'(req.node_threads);
        ones = 0;
        for (k = 0; k < socks * cps && k < 64; k++)
            if (req.core_mask[k])
                ones++;
        room = ones * tpc;
        if (pick < 12)
            req.cpu_count = 16'($urandom_range(65535));
        else if (pick < 17)
            req.cpu_count = '0;
        else if (pick < 30)
            req.cpu_count = 16'(room + int'($urandom_range(5, 1)));
        else if (room > 0)
            req.cpu_count = 16'($urandom_range(room, 1));
        else
            req.cpu_count = 16'($urandom_range(3, 1));
        return req;
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTED)
            $display("ERROR @%0t: %s", $realtime, what);
        error_count++;
    endtask

    // Starts and ends at a falling edge; valid is left high for the next request.
    task automatic send_request(input cmt_pkg::cmt_in_t req);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        expected_trims.push_back(predict_trim(req, trim_mode_q, thread_limit_q));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_trims.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [cmt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cmt_pkg::CFG_DATA_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == cmt_pkg::REG_MODE)
            trim_mode_q = value[0];
        else
            thread_limit_q = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int gap_pct, input int stall_pct);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
    endtask

    task automatic test_directed_cases();
        set_idling(0, 0);
        write_reg(cmt_pkg::REG_MODE, cmt_pkg::CFG_DATA_W'(TRIM_BLOCK));
        write_reg(cmt_pkg::REG_THREADS, 8'd1);
        // Nothing wanted, oversized layouts, exact fit of all 64 bits.
        send_request(cmt_pkg::cmt_in_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd2, 7'd4, 8'd1, 16'd0});
        send_request(cmt_pkg::cmt_in_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 7'd64, 8'd255, 16'd1});
        send_request(cmt_pkg::cmt_in_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd3, 7'd22, 8'd1, 16'd1});
        send_request(cmt_pkg::cmt_in_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 7'd8, 8'd1, 16'd64});
        // Bits above the layout are dropped; too few cores keeps the whole layout.
        send_request(cmt_pkg::cmt_in_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 7'd4, 8'd1, 16'hFFFF});
        send_request(cmt_pkg::cmt_in_t'{64'h0, 4'd4, 7'd4, 8'd2, 16'd1});
        send_request(cmt_pkg::cmt_in_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 7'd64, 8'd255, 16'hFFFF});
        send_request(cmt_pkg::cmt_in_t'{64'hAAAA_AAAA_AAAA_AAAA, 4'd2, 7'd32, 8'd3, 16'd5});
        send_request(cmt_pkg::cmt_in_t'{64'h8000_0000_0000_0000, 4'd1, 7'd64, 8'd1, 16'd1});
        send_request(cmt_pkg::cmt_in_t'{64'h5555_5555_5555_5555, 4'd1, 7'd63, 8'd128, 16'd7});
        write_reg(cmt_pkg::REG_MODE, cmt_pkg::CFG_DATA_W'(TRIM_CYCLIC));
        write_reg(cmt_pkg::REG_THREADS, 8'd255);
        // The last round still takes one core from every socket.
        send_request(cmt_pkg::cmt_in_t'{64'h0000_0000_0000_FFFF, 4'd4, 7'd4, 8'd2, 16'd6});
        send_request(cmt_pkg::cmt_in_t'{64'h0000_0000_0000_F0FF, 4'd4, 7'd4, 8'd1, 16'd7});
        send_request(cmt_pkg::cmt_in_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 7'd8, 8'd255, 16'hFFFF});
        send_request(cmt_pkg::cmt_in_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 7'd8, 8'd1, 16'd0});
        send_request(cmt_pkg::cmt_in_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 7'd10, 8'd1, 16'd3});
        send_request(cmt_pkg::cmt_in_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 7'd8, 8'd1, 16'd64});
        send_request(cmt_pkg::cmt_in_t'{64'h0F0F_0F0F_0F0F_0F0F, 4'd8, 7'd8, 8'd3, 16'd20});
        write_reg(cmt_pkg::REG_THREADS, 8'd1);
        send_request(cmt_pkg::cmt_in_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 7'd64, 8'd255, 16'd64});
        send_request(cmt_pkg::cmt_in_t'{64'h0000_0001_8000_0001, 4'd2, 7'd32, 8'd4, 16'd3});
        send_request(cmt_pkg::cmt_in_t'{64'h0000_0000_0000_0F00, 4'd3, 7'd4, 8'd2, 16'd2});
    endtask

    // Empty layouts, too many sockets, oversized core counts and zero threads.
    task automatic test_degenerate_inputs();
        int m;
        set_idling(0, 0);
        for (m = 0; m < 2; m++)
        begin
            write_reg(cmt_pkg::REG_MODE, cmt_pkg::CFG_DATA_W'(m));
            write_reg(cmt_pkg::REG_THREADS, 8'd2);
            send_request(cmt_pkg::cmt_in_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 7'd1, 8'd1, 16'd1});
            send_request(cmt_pkg::cmt_in_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 7'd0, 8'd1, 16'd1});
            send_request(cmt_pkg::cmt_in_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 7'd127, 8'd1, 16'd1});
            send_request(cmt_pkg::cmt_in_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 7'd8, 8'd1, 16'd1});
            send_request(cmt_pkg::cmt_in_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd4, 7'd0, 8'd1, 16'd0});
            send_request(cmt_pkg::cmt_in_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd2, 7'd4, 8'd0, 16'd3});
            write_reg(cmt_pkg::REG_THREADS, 8'd0);
            send_request(cmt_pkg::cmt_in_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd2, 7'd4, 8'd4, 16'd1});
            send_request(cmt_pkg::cmt_in_t'{64'hFFFF_FFFF_FFFF_FFFF, 4'd2, 7'd4, 8'd4, 16'd0});
        end
    endtask

    // Runs one random segment per idle pattern, changing the thread limit each time.
    task automatic run_random_segments(input logic mode, input logic [7:0] limit_a,
                                       input logic [7:0] limit_b);
        int seg;
        int n;
        logic [7:0] limit;
        write_reg(cmt_pkg::REG_MODE, cmt_pkg::CFG_DATA_W'(mode));
        for (seg = 0; seg < 4; seg++)
        begin
            case (seg)
                0:       limit = limit_a;
                1:       limit = limit_b;
                2:       limit = 8'($urandom_range(8, 2));
                default: limit = 8'($urandom_range(255, 1));
            endcase
            write_reg(cmt_pkg::REG_THREADS, limit);
            case (seg)
                0:       set_idling(0, 0);
                1:       set_idling(53, 0);
                2:       set_idling(0, 53);
                default: set_idling(7, 7);
            endcase
            for (n = 0; n < SEGMENT_REQUESTS; n++)
                send_request(random_request());
        end
    endtask

    task automatic test_block_random();
        run_random_segments(TRIM_BLOCK, 8'd1, 8'd255);
    endtask

    task automatic test_cyclic_random();
        run_random_segments(TRIM_CYCLIC, 8'd255, 8'd1);
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_trims.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                if (out_data.kept_mask !== expected_trims[0].kept_mask)
                    report_mismatch($sformatf("kept_mask %h, expected %h",
                                              out_data.kept_mask,
                                              expected_trims[0].kept_mask));
                if (out_data.status !== expected_trims[0].status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              out_data.status, expected_trims[0].status));
                void'(expected_trims.pop_front());
            end
        end
    end

    // Ends the run if no channel moves a request for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        trim_mode_q    = TRIM_BLOCK;
        thread_limit_q = 8'd1;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_degenerate_inputs();
        test_block_random();
        test_cyclic_random();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_trims.size() != 0)
            report_mismatch("results still outstanding at end of run");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
design/cmt_pkg.sv
design/core_mask_trim.sv
tb/tb_core_mask_trim.sv
